// ----- rtl/dedt_pkg.sv -----
package dedt_pkg;

  // depth result and configuration register widths
  localparam int DEPTH_W   = 16;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_AM_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FM_LIMIT = 1'b1;

  localparam logic [CFG_W-1:0]   AM_LIMIT_RESET = 12'd200;
  localparam logic [CFG_W-1:0]   FM_LIMIT_RESET = 12'd150;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX      = 16'hFFFF;

  // average and depth operations, in the order the controller runs them
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_AM_MAX = 3'd0;
  localparam logic [OP_W-1:0] OP_AM_MIN = 3'd1;
  localparam logic [OP_W-1:0] OP_FM_MAX = 3'd2;
  localparam logic [OP_W-1:0] OP_FM_MIN = 3'd3;
  localparam logic [OP_W-1:0] OP_DEPTH  = 3'd4;

  typedef struct packed {
    logic            take;       // sample transfer, update frame extremes
    logic            push;       // push extremes into histories
    logic            div_start;
    logic [OP_W-1:0] op;
    logic            load_out;
  } dedt_cmd_t;

  typedef struct packed {
    logic div_done;
  } dedt_sts_t;

endpackage

// ----- rtl/dedt_div.sv -----
module dedt_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;

  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;
  logic             fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_r};
  assign fits  = !diff[DEN_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ----- rtl/dedt_datapath.sv -----
module dedt_datapath #(
  parameter int HISTORY_DEPTH = 20,
  parameter int SAMPLE_BITS   = 12,
  parameter int OUT_W         = 80
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dedt_pkg::dedt_cmd_t               cmd,
  output dedt_pkg::dedt_sts_t               sts,
  input  logic [SAMPLE_BITS-1:0]            sample_am,
  input  logic [SAMPLE_BITS-1:0]            sample_fm,
  input  logic                              cfg_wen,
  input  logic [dedt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dedt_pkg::CFG_W-1:0]        cfg_wdata,
  output logic [OUT_W-1:0]                  out_data
);

  import dedt_pkg::*;

  localparam int SB        = SAMPLE_BITS;
  localparam int SUM_W     = SB + $clog2(HISTORY_DEPTH);
  localparam int NUM_W     = SB + DEPTH_W;
  localparam int DEN_W     = SB + 1;
  localparam int CMP_W     = (SB > CFG_W) ? SB : CFG_W;
  localparam int OUT_PAY   = 5 * SB + DEPTH_W + 2;
  localparam int AVG_SHIFT = SUM_W + $clog2(HISTORY_DEPTH);
  localparam int PROD_W    = 2 * SUM_W + 1;
  // ceil(2^AVG_SHIFT / HISTORY_DEPTH), exact truncated mean for any sum below 2^SUM_W
  localparam logic [SUM_W:0] AVG_RECIP =
    (SUM_W+1)'(((64'd1 << AVG_SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

  // channel order: am max, am min, fm max, fm min
  logic [SB-1:0]    ext_r [4];
  logic [SB-1:0]    ext_nxt [4];
  logic [SB-1:0]    hist_r [4][HISTORY_DEPTH];
  logic [SUM_W-1:0] sum_r [4];
  logic [SB-1:0]    avg_r [4];
  logic [DEPTH_W-1:0] depth_r;
  logic [CFG_W-1:0] am_limit_r;
  logic [CFG_W-1:0] fm_limit_r;
  logic [OUT_W-1:0] out_data_r;
  logic             mul_done_r;

  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] div_quot;
  logic             div_done;
  logic             div_start;

  logic             avg_start;
  logic [SUM_W-1:0] avg_sum;
  logic [PROD_W-1:0] avg_prod;
  logic [SB-1:0]    avg_q;

  logic [SB-1:0]    am_span;
  logic [SB-1:0]    fm_span;
  logic [DEN_W-1:0] am_den;
  logic             am_flat;
  logic             carrier;
  logic [DEPTH_W-1:0] depth_val;
  logic [OUT_W-1:0] payload;

  always_comb begin
    ext_nxt[0] = (sample_am > ext_r[0]) ? sample_am : ext_r[0];
    ext_nxt[1] = (sample_am < ext_r[1]) ? sample_am : ext_r[1];
    ext_nxt[2] = (sample_fm > ext_r[2]) ? sample_fm : ext_r[2];
    ext_nxt[3] = (sample_fm < ext_r[3]) ? sample_fm : ext_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r[0] <= '0;
      ext_r[1] <= '1;
      ext_r[2] <= '0;
      ext_r[3] <= '1;
    end else if (cmd.push) begin
      ext_r[0] <= '0;
      ext_r[1] <= '1;
      ext_r[2] <= '0;
      ext_r[3] <= '1;
    end else if (cmd.take) begin
      ext_r <= ext_nxt;
    end
  end

  // history shift lines with running sums: new entry in, oldest out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        sum_r[k] <= '0;
        for (int i = 0; i < HISTORY_DEPTH; i++) hist_r[k][i] <= '0;
      end
    end else if (cmd.push) begin
      for (int k = 0; k < 4; k++) begin
        sum_r[k] <= sum_r[k] + SUM_W'(ext_r[k]) - SUM_W'(hist_r[k][0]);
        for (int i = 0; i < HISTORY_DEPTH - 1; i++) hist_r[k][i] <= hist_r[k][i+1];
        hist_r[k][HISTORY_DEPTH-1] <= ext_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      am_limit_r <= AM_LIMIT_RESET;
      fm_limit_r <= FM_LIMIT_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_AM_LIMIT: am_limit_r <= cfg_wdata;
        REG_FM_LIMIT: fm_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign am_span = (avg_r[0] > avg_r[1]) ? avg_r[0] - avg_r[1] : '0;
  assign fm_span = (avg_r[2] > avg_r[3]) ? avg_r[2] - avg_r[3] : '0;
  assign am_den  = {1'b0, avg_r[0]} + {1'b0, avg_r[1]};

  // averages by a combinational reciprocal multiply, only the depth uses the divider
  assign avg_start = cmd.div_start && (cmd.op != OP_DEPTH);
  assign div_start = cmd.div_start && (cmd.op == OP_DEPTH);
  assign avg_sum   = sum_r[cmd.op[1:0]];
  assign avg_prod  = PROD_W'(avg_sum) * PROD_W'(AVG_RECIP);
  assign avg_q     = avg_prod[AVG_SHIFT +: SB];

  assign div_num = {am_span, {DEPTH_W{1'b0}}};
  assign div_den = am_den;

  dedt_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // zero denominator gives zero, a full-scale quotient saturates
  always_comb begin
    if (am_den == '0) depth_val = '0;
    else if (div_quot[NUM_W-1:DEPTH_W] != '0) depth_val = DEPTH_MAX;
    else depth_val = div_quot[DEPTH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mul_done_r <= 1'b0;
    else mul_done_r <= avg_start;
  end

  always_ff @(posedge clk) begin
    if (avg_start) avg_r[cmd.op[1:0]] <= avg_q;
    if (div_done) depth_r <= depth_val;
  end

  assign am_flat = CMP_W'(am_span) < CMP_W'(am_limit_r);
  assign carrier = am_flat && (CMP_W'(fm_span) < CMP_W'(fm_limit_r));

  always_comb begin
    payload = '0;
    payload[OUT_PAY-1:0] = {am_flat, carrier, fm_span, depth_r,
                            avg_r[3], avg_r[2], avg_r[1], avg_r[0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_data_r <= payload;
  end

  assign out_data     = out_data_r;
  assign sts.div_done = div_done || mul_done_r;

endmodule

// ----- rtl/dedt_ctrl.sv -----
module dedt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tlast,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output dedt_pkg::dedt_cmd_t cmd,
  input  dedt_pkg::dedt_sts_t sts
);

  import dedt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PUSH   = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DWAIT  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [OP_W-1:0] op_r, op_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.op        = op_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.take = 1'b1;
          if (in_tlast) state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        op_nxt    = OP_AM_MAX;
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          if (op_r == OP_DEPTH) begin
            state_nxt = S_FINISH;
          end else begin
            op_nxt    = op_r + 1'b1;
            state_nxt = S_DSTART;
          end
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_AM_MAX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result loaded over an untaken result");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_DWAIT))
    else $error("divider finished outside of wait state");

  a_op_range: assert property (@(posedge clk) disable iff (!rst_n)
    op_r <= OP_DEPTH)
    else $error("divider operation out of range");

  a_push_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH) |=> (state_r == S_DSTART) && (op_r == OP_AM_MAX))
    else $error("push not followed by first average");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> (state_r == S_PUSH))
    else $error("frame end transfer did not start a push");

endmodule

// ----- rtl/dual_envelope_depth_tracker.sv -----
// dual envelope depth tracker
// in_* : one transfer per paired ADC sample, in_tlast marks the last sample of
//   a frame. Samples without in_tlast are accepted back to back.
// out_*: one result per frame, produced after the in_tlast transfer: the four
//   history averages, AM depth (Q0.16), FM span and carrier-only flags.
// after a frame-end transfer the block pushes the frame extremes into the
//   histories, forms the four averages in turn by reciprocal multiply, then
//   runs the depth quotient on a radix-2 divider of SAMPLE_BITS+16
//   iterations. The result becomes valid and in_tready returns at the
//   same edge.
// the result sits in an output register, so new samples are taken while it
//   waits; if the receiver stalls past the next frame end, the block holds
//   in_tready low until the register is taken.
// cfg_*: write-only registers, index 0 AM span limit, index 1 FM span limit;
//   write only while no frame result is pending.
// reset (rst_n low, synchronous) clears histories, frame extremes and limits
//   to their defaults and drops out_tvalid.
module dual_envelope_depth_tracker #(
  parameter int HISTORY_DEPTH = 20,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample_am, sample_fm
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   in_tdata,
  input  logic                                 in_tlast,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // am_max_avg, am_min_avg, fm_max_avg, fm_min_avg, am_depth, fm_span,
  // carrier_only, am_flat
  output logic [((5*SAMPLE_BITS+18+7)/8)*8-1:0] out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_wen,
  input  logic [dedt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dedt_pkg::CFG_W-1:0]           cfg_wdata
);

  import dedt_pkg::*;

  localparam int OUT_W = ((5 * SAMPLE_BITS + DEPTH_W + 2 + 7) / 8) * 8;

  dedt_cmd_t cmd;
  dedt_sts_t sts;

  dedt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  dedt_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .OUT_W         (OUT_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .sample_am (in_tdata[SAMPLE_BITS-1:0]),
    .sample_fm (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_tdata)
  );

endmodule
